>>> rtl/core/acfr_pkg.sv
// Package for the ASCII command frame receiver.
// Holds shared constants, the action codes, the decode record and the decode function.
// No dependencies.
`timescale 1ns / 1ps

package acfr_pkg;

  localparam int unsigned FrameBytesDef = 8;
  localparam int unsigned HdrBytes      = 6;

  localparam logic [15:0] TimeoutReset = 16'h8000;
  localparam logic [15:0] PollMax      = 16'hFFFF;

  localparam logic [7:0] CharF      = 8'h46;
  localparam logic [7:0] CharDollar = 8'h24;
  localparam logic [7:0] Char0      = 8'h30;
  localparam logic [7:0] Char1      = 8'h31;
  localparam logic [7:0] Char2      = 8'h32;
  localparam logic [7:0] Char3      = 8'h33;
  localparam logic [7:0] DecTen     = 8'd10;

  localparam logic RegTimeout = 1'b0;

  typedef enum logic [2:0] {
    ActNone     = 3'd0,
    ActConfirm  = 3'd1,
    ActSetGreen = 3'd2,
    ActSetRed   = 3'd3,
    ActStop     = 3'd4,
    ActResume   = 3'd5
  } acfr_action_e;

  typedef struct packed {
    logic         frame_ok;
    acfr_action_e action;
    logic [7:0]   time_value;
  } acfr_decode_t;

  function automatic acfr_decode_t acfr_decode(input logic [7:0]  b0,
                                               input logic [7:0]  b2,
                                               input logic [7:0]  b3,
                                               input logic [7:0]  b4,
                                               input logic [7:0]  b5,
                                               input logic [15:0] polls,
                                               input logic [15:0] limit);
    acfr_decode_t r;
    logic [7:0]   d4;
    logic [7:0]   d5;
    logic [7:0]   tens;
    d4   = b4 - Char0;
    d5   = b5 - Char0;
    tens = 8'(d4 * DecTen);
    r.frame_ok   = (polls < limit) && (b0 == CharDollar);
    r.action     = ActNone;
    r.time_value = '0;
    if (r.frame_ok) begin
      if (b2 == Char0) begin
        r.action = ActConfirm;
      end else if (b2 == Char1) begin
        if (b3 == Char1) begin
          r.action = ActSetGreen;
        end else if (b3 == Char2) begin
          r.action = ActSetRed;
        end
        if (r.action != ActNone) begin
          r.time_value = tens + d5;
        end
      end else if (b2 == Char2) begin
        r.action = ActStop;
      end else if (b2 == Char3) begin
        r.action = ActResume;
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/core/ascii_command_frame_receiver_unit.sv
// Top level of the ASCII command frame receiver: poll sequencer, header
// registers, timeout register and echo buffer. Depends on acfr_pkg and acfr_echo_buf.
`timescale 1ns / 1ps

// Usage:
// Each request on the s_axis channel is one poll; tuser marks that tdata holds a
// received byte. Idle and receive polls are taken one per cycle while no echo
// pass runs, and give no result. The poll that follows the closing of a frame
// gives one m_axis result per held byte (1 to FRAME_BYTES), in arrival order;
// tlast marks the final one, which also carries frame_ok, action and time_value.
// Accepting that poll sets the busy flag; the buffer read port then delivers
// one echo per cycle while m_axis is ready, and the input is held off while
// the echo pass runs.
// A stalled m_axis holds its result in the read data register and halts the echo
// pass; the input stays held off until the last read of that pass is issued.
// Reset returns to idle, drops any pending echo and loads timeout_limit with
// 0x8000. The APB port holds timeout_limit at address 0; pready is always high.
// The buffer needs no clearing pass: only bytes of the current frame are echoed,
// and the header bytes used for decoding are cleared at frame start.

module ascii_command_frame_receiver_unit
  import acfr_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = FrameBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tuser: [0] has_byte
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,
  // tdata: [7:0] echo_byte, [8] frame_ok, [11:9] action, [19:12] time_value,
  //        [23:20] zero; tlast: is_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CntW  = $clog2(FRAME_BYTES + 1);
  localparam int unsigned AddrW = $clog2(FRAME_BYTES);

  typedef enum logic [2:0] {
    PhIdle    = 3'b001,
    PhReceive = 3'b010,
    PhProcess = 3'b100
  } acfr_phase_e;

  acfr_phase_e      phase_q, phase_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [15:0]      poll_q, poll_d;
  logic [15:0]      limit_q;
  logic [7:0]       hdr_q [HdrBytes];
  logic [7:0]       hdr_d [HdrBytes];
  logic [7:0]       lastb_q, lastb_d;

  logic             in_fire;
  logic             wr_en;
  logic [CntW-1:0]  wr_idx;
  logic             start;
  logic             busy;
  logic [15:0]      poll_inc;
  logic             closes;
  acfr_decode_t     dec;
  acfr_decode_t     out_dec;
  logic [7:0]       out_byte;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= TimeoutReset;
    end else if (cfg_wr && paddr[2] == RegTimeout) begin
      limit_q <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == RegTimeout) ? {16'h0, limit_q} : '0;

  assign s_axis_tready = !busy;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign poll_inc = (poll_q == PollMax) ? poll_q : poll_q + 16'd1;

  assign closes = (poll_inc > limit_q) ||
                  (lastb_q == CharF) ||
                  (cnt_q >= CntW'(FRAME_BYTES)) ||
                  ((cnt_q >= CntW'(2)) && (hdr_q[1] >= Char0) &&
                   (8'(cnt_q) >= hdr_q[1] - Char0));

  assign dec = acfr_decode(hdr_q[0], hdr_q[2], hdr_q[3], hdr_q[4], hdr_q[5],
                           poll_q, limit_q);

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    poll_d  = poll_q;
    lastb_d = lastb_q;
    wr_en   = 1'b0;
    wr_idx  = cnt_q;
    start   = 1'b0;
    for (int i = 0; i < HdrBytes; i++) begin
      hdr_d[i] = hdr_q[i];
    end
    if (in_fire) begin
      unique case (phase_q)
        PhIdle: begin
          cnt_d  = '0;
          poll_d = '0;
          if (s_axis_tuser) begin
            wr_en   = 1'b1;
            wr_idx  = '0;
            cnt_d   = CntW'(1);
            lastb_d = s_axis_tdata;
            phase_d = PhReceive;
            for (int i = 0; i < HdrBytes; i++) begin
              hdr_d[i] = '0;
            end
            hdr_d[0] = s_axis_tdata;
          end
        end
        PhReceive: begin
          poll_d = poll_inc;
          if (closes) begin
            phase_d = PhProcess;
          end else if (s_axis_tuser && cnt_q < CntW'(FRAME_BYTES)) begin
            wr_en   = 1'b1;
            cnt_d   = cnt_q + CntW'(1);
            poll_d  = '0;
            lastb_d = s_axis_tdata;
            for (int i = 0; i < HdrBytes; i++) begin
              if (cnt_q == CntW'(i)) begin
                hdr_d[i] = s_axis_tdata;
              end
            end
          end
        end
        PhProcess: begin
          start   = 1'b1;
          phase_d = PhIdle;
        end
        default: begin
          phase_d = PhIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      cnt_q   <= '0;
      poll_q  <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      poll_q  <= poll_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lastb_q <= lastb_d;
    for (int i = 0; i < HdrBytes; i++) begin
      hdr_q[i] <= hdr_d[i];
    end
  end

  acfr_echo_buf #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_echo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_idx[AddrW-1:0]),
    .wr_data_i(s_axis_tdata),
    .start_i  (start),
    .count_i  (cnt_q),
    .dec_i    (dec),
    .busy_o   (busy),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .byte_o   (out_byte),
    .last_o   (m_axis_tlast),
    .dec_o    (out_dec)
  );

  assign m_axis_tdata = {4'h0, out_dec.time_value, out_dec.action, out_dec.frame_ok,
                         out_byte};

`ifndef SYNTHESIS
  a_no_input_during_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !s_axis_tready)
    else $error("input accepted during echo pass");

  a_process_starts_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && phase_q == PhProcess) |=> (busy && phase_q == PhIdle))
    else $error("process poll did not start an echo pass");

  a_no_action_without_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[8]) |-> (m_axis_tdata[19:9] == 11'h0))
    else $error("action or time reported on a frame that is not ok");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (wr_idx < CntW'(FRAME_BYTES)))
    else $error("buffer write beyond frame size");
`endif

endmodule

>>> rtl/core/acfr_echo_buf.sv
// Frame byte buffer and echo sequencer of the ASCII command frame receiver.
// One write port from the receive logic, one registered read port for the echo.
// Depends on acfr_pkg.
`timescale 1ns / 1ps

module acfr_echo_buf
  import acfr_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = FrameBytesDef,
  localparam int unsigned CntW       = $clog2(FRAME_BYTES + 1),
  localparam int unsigned AddrW      = $clog2(FRAME_BYTES)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [7:0]       wr_data_i,
  input  logic             start_i,
  input  logic [CntW-1:0]  count_i,
  input  acfr_decode_t     dec_i,
  output logic             busy_o,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [7:0]       byte_o,
  output logic             last_o,
  output acfr_decode_t     dec_o
);

  logic [7:0] mem [FRAME_BYTES];

  logic               busy_q, busy_d;
  logic [CntW-1:0]    ptr_q, ptr_d;
  logic [CntW-1:0]    cnt_q;
  acfr_decode_t       dec_q;
  logic               valid_q, valid_d;
  logic [7:0]         rdata_q;
  logic               last_q;
  acfr_decode_t       odec_q;
  logic               ren;
  logic               last_rd;

  assign ren     = busy_q && (!valid_q || ready_i);
  assign last_rd = (ptr_q == cnt_q - CntW'(1));

  always_comb begin
    busy_d  = busy_q;
    ptr_d   = ptr_q;
    valid_d = valid_q;
    if (ready_i) begin
      valid_d = 1'b0;
    end
    if (ren) begin
      valid_d = 1'b1;
      ptr_d   = ptr_q + CntW'(1);
      if (last_rd) begin
        busy_d = 1'b0;
      end
    end
    if (start_i) begin
      busy_d = 1'b1;
      ptr_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      ptr_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      ptr_q   <= ptr_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      cnt_q <= count_i;
      dec_q <= dec_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ren) begin
      rdata_q <= mem[ptr_q[AddrW-1:0]];
      last_q  <= last_rd;
      odec_q  <= last_rd ? dec_q : '0;
    end
  end

  assign busy_o  = busy_q;
  assign valid_o = valid_q;
  assign byte_o  = rdata_q;
  assign last_o  = last_q;
  assign dec_o   = odec_q;

endmodule
